// ----- rtl/rwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwm_pkg
// Shared types and constants of the rgb window median filter.
// ----------------------------------------------------------------------------
package rwm_pkg;

	localparam int CHAN_W   = 8;
	localparam int CHANNELS = 3;

	// operation codes of an input transaction
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

	// register reset values
	localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
	localparam logic [15:0] RST_FRAME_HEIGHT  = 16'd480;
	localparam logic [1:0]  RST_WINDOW_RADIUS = 2'd1;

	// result queue
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = 4;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pix_t;

	typedef struct packed {
		logic              frame_end;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} result_t;

endpackage

// ----- rtl/rgb_window_median_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_window_median_filter
// Per-channel square-window median over a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries pixel transactions
//   (operation = pixel) in raster order and flush transactions once the frame
//   is in. Output channel (out_valid/out_ready) carries one median pixel per
//   frame position; frame_end marks the last one.
//   Output position q is produced by the pixel transaction that brings the
//   received count to q + radius*width + radius + 1; after the frame each
//   flush produces the next position. Early flushes and surplus pixels are
//   taken and dropped.
//   A result passes the stage 1 and stage 2 registers, the rank select chain
//   and the result queue before out_valid. One transaction is taken per
//   cycle; frames smaller than radius rows plus radius pixels pause the input
//   after the last pixel while the window column loader catches up.
//   A 16-entry result queue separates the sides: input keeps flowing while
//   results wait, and in_ready also drops when 16 results are in flight.
//   Reset (arst_n low) empties the pipeline and queue, restarts the frame and
//   loads 640x480, radius 1. A register write also restarts the frame.
//   Line buffers are undefined after reset; no unwritten entry reaches a median.
// ----------------------------------------------------------------------------
module rgb_window_median_filter #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        frame_end,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int WD     = 2 * MAX_RADIUS + 1;
	localparam int NB     = WD;
	localparam int N      = WD * WD;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W  = (WID_W > 12) ? WID_W : 12;
	localparam int BANK_W = $clog2(NB);
	localparam int ROW_W  = 17;
	localparam int LIN_W  = WID_W + 17;
	localparam int K_W    = $clog2(N + 1);
	localparam int NBIT   = rwm_pkg::CHAN_W;
	localparam int OCC_W  = rwm_pkg::FIFO_AW + 1;

	typedef struct packed {
		logic              ins;
		logic              emit;
		logic              byp;
		logic              fe;
		logic [BANK_W-1:0] bank;
		logic [WD-1:0]     rowm;
		logic [WD-1:0]     colm;
	} s1_ctl_t;

	// configuration registers
	logic [11:0] frame_width_q;
	logic [15:0] frame_height_q;
	logic [1:0]  window_radius_q;
	logic        cfg_restart;

	// frame counters
	logic [COL_W-1:0]  in_col_q, ins_col_q, out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [BANK_W-1:0] in_bank_q, ins_bank_q;
	logic [LIN_W-1:0]  in_lin_q, ins_lin_q, out_lin_q;

	logic [CMP_W-1:0] fw_ext;
	logic [WID_W-1:0] w_eff;
	logic [15:0]      h_eff;
	logic [1:0]       r_eff;
	logic [LIN_W-1:0] total, rw;

	logic in_done, fill, acc, data_take, flush_take, ins_go, emit_go, last;
	logic [OCC_W-1:0] occ_q;

	logic [WD-1:0] rowm_n, colm_n;
	s1_ctl_t       ctl_s1;
	rwm_pkg::pix_t pix_s1;
	rwm_pkg::pix_t rd_data [NB];
	rwm_pkg::pix_t col_pix [WD];
	rwm_pkg::pix_t win_q [WD][WD];
	rwm_pkg::pix_t win_n [WD][WD];

	logic         emit_s2, fe_s2;
	logic [N-1:0] mask_s2;
	logic [K_W-1:0] cnt_n;

	logic [N-1:0][NBIT-1:0] vals_s3 [rwm_pkg::CHANNELS];
	logic [N-1:0]           cand_s3;
	logic [K_W-1:0]         k_s3;

	logic [N-1:0][NBIT-1:0] vals_ch [rwm_pkg::CHANNELS][NBIT+1];
	logic [N-1:0]           cand_ch [rwm_pkg::CHANNELS][NBIT+1];
	logic [K_W-1:0]         k_ch    [rwm_pkg::CHANNELS][NBIT+1];
	logic [NBIT-1:0]        res_ch  [rwm_pkg::CHANNELS][NBIT+1];
	logic                   vld_q   [NBIT+1];
	logic                   fe_q    [NBIT+1];

	rwm_pkg::result_t            fifo_q [rwm_pkg::FIFO_DEPTH];
	logic [rwm_pkg::FIFO_AW-1:0] wptr_q, rptr_q;
	logic [OCC_W-1:0]            fifo_cnt_q;
	logic                        pop;

	// effective geometry
	always_comb begin
		fw_ext = CMP_W'(frame_width_q);
		if (fw_ext == '0) begin
			w_eff = WID_W'(1);
		end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(fw_ext);
		end
		h_eff = (frame_height_q == '0) ? 16'd1 : frame_height_q;
		r_eff = (32'(window_radius_q) > 32'(MAX_RADIUS)) ? 2'(MAX_RADIUS)
		                                                 : window_radius_q;
		total = LIN_W'(w_eff) * LIN_W'(h_eff);
		rw    = LIN_W'(w_eff) * LIN_W'(r_eff);
	end

	// launch decisions
	assign in_done    = in_lin_q >= total;
	assign fill       = in_done && (ins_lin_q < out_lin_q + LIN_W'(r_eff));
	assign in_ready   = !fill && (occ_q < OCC_W'(rwm_pkg::FIFO_DEPTH));
	assign acc        = in_valid && in_ready;
	assign data_take  = acc && (operation == rwm_pkg::OP_PIXEL) && !in_done;
	assign flush_take = acc && (operation == rwm_pkg::OP_FLUSH) && in_done;
	assign ins_go     = fill || flush_take || (data_take && (in_lin_q >= rw));
	assign emit_go    = flush_take ||
	                    (data_take && (in_lin_q >= out_lin_q + rw + LIN_W'(r_eff)));
	assign last       = (out_lin_q + LIN_W'(1)) >= total;
	assign cfg_restart = cfg_we && (cfg_index == rwm_pkg::REG_FRAME_WIDTH ||
	                                cfg_index == rwm_pkg::REG_FRAME_HEIGHT ||
	                                cfg_index == rwm_pkg::REG_WINDOW_RADIUS);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= rwm_pkg::RST_FRAME_WIDTH;
			frame_height_q  <= rwm_pkg::RST_FRAME_HEIGHT;
			window_radius_q <= rwm_pkg::RST_WINDOW_RADIUS;
		end else if (cfg_we) begin
			case (cfg_index)
				rwm_pkg::REG_FRAME_WIDTH:   frame_width_q   <= cfg_data[11:0];
				rwm_pkg::REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data;
				rwm_pkg::REG_WINDOW_RADIUS: window_radius_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// input, column loader and output position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_bank_q  <= '0;
			in_lin_q   <= '0;
			ins_col_q  <= '0;
			ins_bank_q <= '0;
			ins_lin_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_lin_q  <= '0;
		end else if (cfg_restart || (emit_go && last)) begin
			in_col_q   <= '0;
			in_bank_q  <= '0;
			in_lin_q   <= '0;
			ins_col_q  <= '0;
			ins_bank_q <= '0;
			ins_lin_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_lin_q  <= '0;
		end else begin
			if (data_take) begin
				in_lin_q <= in_lin_q + LIN_W'(1);
				if (WID_W'(in_col_q) + WID_W'(1) >= w_eff) begin
					in_col_q  <= '0;
					in_bank_q <= (in_bank_q == BANK_W'(NB - 1)) ? '0 : in_bank_q + BANK_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (ins_go) begin
				ins_lin_q <= ins_lin_q + LIN_W'(1);
				if (WID_W'(ins_col_q) + WID_W'(1) >= w_eff) begin
					ins_col_q  <= '0;
					ins_bank_q <= (ins_bank_q == BANK_W'(NB - 1)) ? '0 : ins_bank_q + BANK_W'(1);
				end else begin
					ins_col_q <= ins_col_q + COL_W'(1);
				end
			end
			if (emit_go) begin
				out_lin_q <= out_lin_q + LIN_W'(1);
				if (WID_W'(out_col_q) + WID_W'(1) >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// results in flight or queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(emit_go) - OCC_W'(pop);
		end
	end

	// border masks of the output position
	always_comb begin
		int oy;
		int ox;
		int dy;
		int dx;
		int r;
		oy = int'(out_row_q);
		ox = int'(out_col_q);
		r  = int'(r_eff);
		for (int i = 0; i < WD; i++) begin
			dy = i - MAX_RADIUS;
			rowm_n[i] = (dy >= -r) && (dy <= r) && (oy + dy >= 0) &&
			            (oy + dy < int'(h_eff));
		end
		for (int j = 0; j < WD; j++) begin
			dx = j - (WD - 1) + r;
			colm_n[j] = (dx >= -r) && (ox + dx >= 0) && (ox + dx < int'(w_eff));
		end
	end

	// line buffer banks, one row of the window each
	for (genvar b = 0; b < NB; b++) begin : g_bank
		rwm_ram #(
			.WIDTH ($bits(rwm_pkg::pix_t)),
			.DEPTH (MAX_WIDTH)
		) u_ram (
			.clk   (clk),
			.we    (data_take && (in_bank_q == BANK_W'(b))),
			.waddr (in_col_q),
			.wdata ({blue_in, green_in, red_in}),
			.raddr (ins_col_q),
			.rdata (rd_data[b])
		);
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.ins  <= ins_go;
			ctl_s1.emit <= emit_go;
			ctl_s1.byp  <= data_take;
			ctl_s1.fe   <= last;
			ctl_s1.bank <= ins_bank_q;
			ctl_s1.rowm <= rowm_n;
			ctl_s1.colm <= colm_n;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= {blue_in, green_in, red_in};
	end

	// route banks to window rows, newest row bypassed on a same-cycle write
	always_comb begin
		int idx;
		for (int i = 0; i < WD; i++) begin
			idx = int'(ctl_s1.bank) + i + NB - MAX_RADIUS;
			if (idx >= NB) idx = idx - NB;
			if (idx >= NB) idx = idx - NB;
			if (ctl_s1.byp && (i == MAX_RADIUS + int'(r_eff))) begin
				col_pix[i] = pix_s1;
			end else begin
				col_pix[i] = rd_data[BANK_W'(idx)];
			end
		end
	end

	// window shift: one column in at the right edge
	always_comb begin
		win_n = win_q;
		if (ctl_s1.ins) begin
			for (int i = 0; i < WD; i++) begin
				for (int j = 0; j < WD - 1; j++) begin
					win_n[i][j] = win_q[i][j+1];
				end
				win_n[i][WD-1] = col_pix[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_n;
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		fe_s2 <= ctl_s1.fe;
		for (int i = 0; i < WD; i++) begin
			for (int j = 0; j < WD; j++) begin
				mask_s2[i*WD+j] <= ctl_s1.rowm[i] & ctl_s1.colm[j];
			end
		end
	end

	// count window members, rank of the median is count/2
	always_comb begin
		cnt_n = '0;
		for (int i = 0; i < N; i++) begin
			cnt_n = cnt_n + K_W'(mask_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < WD; i++) begin
			for (int j = 0; j < WD; j++) begin
				vals_s3[0][i*WD+j] <= win_q[i][j].red;
				vals_s3[1][i*WD+j] <= win_q[i][j].green;
				vals_s3[2][i*WD+j] <= win_q[i][j].blue;
			end
		end
		cand_s3 <= mask_s2;
		k_s3    <= cnt_n >> 1;
	end

	// rank select chain, one cell per bit and channel
	for (genvar c = 0; c < rwm_pkg::CHANNELS; c++) begin : g_chan
		assign vals_ch[c][0] = vals_s3[c];
		assign cand_ch[c][0] = cand_s3;
		assign k_ch[c][0]    = k_s3;
		assign res_ch[c][0]  = '0;
		for (genvar b = 0; b < NBIT; b++) begin : g_bit
			rwm_select_cell #(
				.N   (N),
				.BIT (NBIT - 1 - b)
			) u_cell (
				.clk    (clk),
				.vals_i (vals_ch[c][b]),
				.cand_i (cand_ch[c][b]),
				.k_i    (k_ch[c][b]),
				.res_i  (res_ch[c][b]),
				.vals_o (vals_ch[c][b+1]),
				.cand_o (cand_ch[c][b+1]),
				.k_o    (k_ch[c][b+1]),
				.res_o  (res_ch[c][b+1])
			);
		end
	end

	// valid and frame end alongside the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b <= NBIT; b++) begin
				vld_q[b] <= 1'b0;
			end
		end else begin
			vld_q[0] <= emit_s2;
			for (int b = 0; b < NBIT; b++) begin
				vld_q[b+1] <= vld_q[b];
			end
		end
	end

	always_ff @(posedge clk) begin
		fe_q[0] <= fe_s2;
		for (int b = 0; b < NBIT; b++) begin
			fe_q[b+1] <= fe_q[b];
		end
	end

	// result queue
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (vld_q[NBIT]) begin
			fifo_q[wptr_q] <= {fe_q[NBIT], res_ch[2][NBIT], res_ch[1][NBIT],
			                   res_ch[0][NBIT]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q     <= '0;
			rptr_q     <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (vld_q[NBIT]) begin
				wptr_q <= wptr_q + rwm_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + rwm_pkg::FIFO_AW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + OCC_W'(vld_q[NBIT]) - OCC_W'(pop);
		end
	end

	assign out_valid = fifo_cnt_q != '0;
	assign red_out   = fifo_q[rptr_q].red;
	assign green_out = fifo_q[rptr_q].green;
	assign blue_out  = fifo_q[rptr_q].blue;
	assign frame_end = fifo_q[rptr_q].frame_end;

endmodule

// ----- rtl/rwm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rwm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/rwm_select_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwm_select_cell
// One bit step of a most-significant-bit-first rank select over a window.
// ----------------------------------------------------------------------------
module rwm_select_cell #(
	parameter int N   = 49,
	parameter int BIT = 7
) (
	input  logic                                 clk,
	input  logic [N-1:0][rwm_pkg::CHAN_W-1:0]    vals_i,
	input  logic [N-1:0]                         cand_i,
	input  logic [$clog2(N+1)-1:0]               k_i,
	input  logic [rwm_pkg::CHAN_W-1:0]           res_i,
	output logic [N-1:0][rwm_pkg::CHAN_W-1:0]    vals_o,
	output logic [N-1:0]                         cand_o,
	output logic [$clog2(N+1)-1:0]               k_o,
	output logic [rwm_pkg::CHAN_W-1:0]           res_o
);

	localparam int K_W = $clog2(N+1);

	logic [N-1:0]   zero_m;
	logic [N-1:0]   one_m;
	logic [K_W-1:0] cnt0;
	logic [N-1:0]   cand_n;
	logic [K_W-1:0] k_n;
	logic [rwm_pkg::CHAN_W-1:0] res_n;

	// count candidates with a zero at this bit
	always_comb begin
		cnt0 = '0;
		for (int i = 0; i < N; i++) begin
			zero_m[i] = cand_i[i] & ~vals_i[i][BIT];
			one_m[i]  = cand_i[i] & vals_i[i][BIT];
			cnt0      = cnt0 + K_W'(zero_m[i]);
		end
	end

	// decide this bit of the ranked value
	always_comb begin
		res_n = res_i;
		if (k_i < cnt0) begin
			cand_n     = zero_m;
			k_n        = k_i;
			res_n[BIT] = 1'b0;
		end else begin
			cand_n     = one_m;
			k_n        = k_i - cnt0;
			res_n[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		vals_o <= vals_i;
		cand_o <= cand_n;
		k_o    <= k_n;
		res_o  <= res_n;
	end

endmodule

// ----- rtl/rwm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwm_checker
// Port-level checks of the rgb window median filter, bound to the top level.
// ----------------------------------------------------------------------------
module rwm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        operation,
	input logic [7:0]  red_in,
	input logic [7:0]  green_in,
	input logic [7:0]  blue_in,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  red_out,
	input logic [7:0]  green_out,
	input logic [7:0]  blue_out,
	input logic        frame_end,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [15:0] cfg_data
);

	// cycles from the producing input transaction to the first valid result
	localparam int LAT = 12;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red_out) && $stable(green_out) &&
		$stable(blue_out) && $stable(frame_end))
		else $error("result payload changed while stalled");

	// nothing is offered in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result offered during reset");

	// a result that appears on an empty output was produced by an input
	// transaction taken the pipeline latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, LAT))
		else $error("result without a producing input transaction");

endmodule

bind rgb_window_median_filter rwm_checker u_rwm_checker (.*);
